// ===== sv/bpsa_pkg.sv =====
`default_nettype none
package bpsa_pkg;

    // item kinds
    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_EOF      = 2'd1;
    localparam logic [1:0] KIND_CLASSIFY = 2'd2;
    localparam logic [1:0] KIND_CLEAR    = 2'd3;

    // flag modes
    localparam logic [1:0] FLAG_SIGMA   = 2'd0;
    localparam logic [1:0] FLAG_RANGE   = 2'd1;
    localparam logic [1:0] FLAG_ALL     = 2'd2;

    // identify modes
    localparam logic [1:0] ID_FIXED    = 2'd0;
    localparam logic [1:0] ID_FRACTION = 2'd1;
    localparam logic [1:0] ID_POISSON  = 2'd2;
    localparam logic [1:0] ID_NONE     = 2'd3;

    // register indexes
    localparam logic [2:0] REG_FLAG_MODE     = 3'd0;
    localparam logic [2:0] REG_BOUND_A       = 3'd1;
    localparam logic [2:0] REG_BOUND_B       = 3'd2;
    localparam logic [2:0] REG_SKIP_MASK     = 3'd3;
    localparam logic [2:0] REG_IDENTIFY_MODE = 3'd4;
    localparam logic [2:0] REG_THRESHOLD     = 3'd5;
    localparam logic [2:0] REG_SET_MASK      = 3'd6;
    localparam logic [2:0] REG_PIXEL_COUNT   = 3'd7;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int HIST_W    = 17;
    localparam int LIM_W     = 50;
    localparam int SQRT_STEPS = 25;
    localparam logic [7:0] FRAMES_MAX = 8'd255;
    localparam logic [HIST_W-1:0] HIST_MAX = '1;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic eof;
        logic clr_start;
        logic clr_step;
        logic hist_rd;
        logic bump_wr1;
        logic bump_wr2;
        logic max_start;
        logic max_rd;
        logic max_cmp;
        logic sqrt_start;
        logic sqrt_step;
        logic lim_simple;
        logic lim_mul;
        logic lim_sub;
        logic out_load;
    } bpsa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_kind;
        logic       clr_last;
        logic       bump_ok;
        logic       need_limit;
        logic       id_poisson;
        logic       mx_last;
        logic       sqrt_last;
        logic       out_free;
    } bpsa_sts_t;

endpackage
`default_nettype wire

// ===== sv/bpsa_in_if.sv =====
`default_nettype none
interface bpsa_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [15:0]        pixel_index;
    logic signed [31:0] sample;
    logic [15:0]        mask_bits;

    modport source (output valid, kind, pixel_index, sample, mask_bits, input ready);
    modport sink   (input valid, kind, pixel_index, sample, mask_bits, output ready);
endinterface
`default_nettype wire

// ===== sv/bpsa_out_if.sv =====
`default_nettype none
interface bpsa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_index_out;
    logic [15:0] mask_out;
    logic [7:0]  suspect_count_out;
    logic        status;

    modport source (output valid, pixel_index_out, mask_out, suspect_count_out, status,
                    input ready);
    modport sink   (input valid, pixel_index_out, mask_out, suspect_count_out, status,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/bad_pixel_suspect_accumulator_core.sv =====
`default_nettype none
// channel   dir  transfer when         payload
// in_ch     in   valid && ready        kind, pixel_index, sample, mask_bits
// out_ch    out  valid && ready        pixel_index_out, mask_out, suspect_count_out, status
// cfg       in   cfg_we                cfg_index, cfg_data
//
// a sample reads its count; when the count is raised it also reads the histogram
// and makes two histogram writes on its single write port
// classify uses a cached, fixed or fraction limit directly, or for the Poisson
// limit first runs a peak scan and a 25-step root
// the pass right after reset sweeps both stores, as does a clear item; a stalled
// result holds the block before it idles
module bad_pixel_suspect_accumulator_core
    import bpsa_pkg::*;
#(
    parameter int NUM_PIXELS = 65536,
    parameter int MAX_COUNT  = 255
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bpsa_in_if.sink                   in_ch,
    bpsa_out_if.source                out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    bpsa_cmd_t cmd;
    bpsa_sts_t sts;

    // sequencing
    bpsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // stores and arithmetic
    bpsa_dp #(
        .NUM_PIXELS (NUM_PIXELS),
        .MAX_COUNT  (MAX_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

// ===== sv/bpsa_ctrl.sv =====
`default_nettype none
module bpsa_ctrl
    import bpsa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  bpsa_sts_t sts,
    output bpsa_cmd_t cmd
);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_SRD  = 4'd2;
    localparam logic [3:0] ST_HRD  = 4'd3;
    localparam logic [3:0] ST_HWR  = 4'd4;
    localparam logic [3:0] ST_CRD  = 4'd5;
    localparam logic [3:0] ST_MAXR = 4'd6;
    localparam logic [3:0] ST_MAXC = 4'd7;
    localparam logic [3:0] ST_SQI  = 4'd8;
    localparam logic [3:0] ST_SQ   = 4'd9;
    localparam logic [3:0] ST_LMUL = 4'd10;
    localparam logic [3:0] ST_LSUB = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    logic [3:0] state_reg, state_next;

    // state register, clearing pass right after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    unique case (sts.in_kind)
                        KIND_SAMPLE:   state_next = ST_SRD;
                        KIND_EOF:      cmd.eof = 1'b1;
                        KIND_CLASSIFY: state_next = ST_CRD;
                        KIND_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SRD:
            begin
                if (sts.bump_ok)
                begin
                    cmd.hist_rd = 1'b1;
                    state_next  = ST_HRD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HRD:
            begin
                cmd.bump_wr1 = 1'b1;
                state_next   = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.bump_wr2 = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_CRD:
            begin
                priority if (!sts.need_limit)
                begin
                    state_next = ST_OUT;
                end
                else if (sts.id_poisson)
                begin
                    cmd.max_start = 1'b1;
                    state_next    = ST_MAXR;
                end
                else
                begin
                    cmd.lim_simple = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_MAXR:
            begin
                cmd.max_rd = 1'b1;
                state_next = ST_MAXC;
            end
            ST_MAXC:
            begin
                cmd.max_cmp = 1'b1;
                state_next  = sts.mx_last ? ST_SQI : ST_MAXR;
            end
            ST_SQI:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                begin
                    state_next = ST_LMUL;
                end
            end
            ST_LMUL:
            begin
                cmd.lim_mul = 1'b1;
                state_next  = ST_LSUB;
            end
            ST_LSUB:
            begin
                cmd.lim_sub = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/bpsa_dp.sv =====
`default_nettype none
module bpsa_dp
    import bpsa_pkg::*;
#(
    parameter int NUM_PIXELS = 65536,
    parameter int MAX_COUNT  = 255
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bpsa_in_if.sink                   in_ch,
    bpsa_out_if.source                out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  bpsa_cmd_t                 cmd,
    output bpsa_sts_t                 sts
);

    localparam int AW    = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int HW    = $clog2(MAX_COUNT + 1);
    localparam int CLR_N = (NUM_PIXELS > MAX_COUNT + 1) ? NUM_PIXELS : MAX_COUNT + 1;
    localparam int CLR_W = $clog2(CLR_N);

    // configuration
    logic [1:0]         flag_mode_reg;
    logic signed [31:0] bound_a_reg;
    logic signed [31:0] bound_b_reg;
    logic [15:0]        skip_mask_reg;
    logic [1:0]         id_mode_reg;
    logic signed [23:0] thr_reg;
    logic [15:0]        set_mask_reg;
    logic [16:0]        pix_count_reg;

    // block state
    logic [7:0]              frames_reg;
    logic                    lim_valid_reg;
    logic signed [LIM_W-1:0] cached_reg;
    logic [CLR_W-1:0]        clr_addr_reg;

    // latched item
    logic [15:0] idx_reg;
    logic        idx_ok_reg;
    logic        sus_reg;

    // memories and read data
    logic [HW-1:0]     cnt_mem [NUM_PIXELS];
    logic [HIST_W-1:0] hist_mem [MAX_COUNT+1];
    logic [HW-1:0]     cnt_q;
    logic [HIST_W-1:0] ha_q, hb_q;

    // histogram peak search and square root
    logic [HW-1:0]           mx_reg, m_reg;
    logic [HIST_W-1:0]       best_reg;
    logic [49:0]             sq_x_reg;
    logic [27:0]             sq_rem_reg;
    logic [24:0]             sq_root_reg;
    logic [4:0]              sq_cnt_reg;
    logic signed [LIM_W-1:0] mul_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] o_idx_reg, o_mask_reg;
    logic [7:0]  o_cnt_reg;
    logic        o_status_reg;

    logic                    take;
    logic                    in_ok;
    logic [AW-1:0]           in_addr;
    logic signed [33:0]      diff, adiff;
    logic                    sus_raw, sus_in;
    logic [HW-1:0]           c_val;
    logic [HW-1:0]           c_inc;
    logic [AW-1:0]           idx_addr;
    logic [16:0]             mp1;
    logic signed [32:0]      frac_prod;
    logic signed [LIM_W-1:0] cnt_shift;
    logic                    reach;
    logic [27:0]             rem_sh, trial;
    logic                    sq_ge;
    logic                    clr_cnt_en, clr_hist_en;
    logic                    cw_en;
    logic [AW-1:0]           cw_addr;
    logic [HW-1:0]           cw_data;
    logic                    hw_en;
    logic [HW-1:0]           hw_addr;
    logic [HIST_W-1:0]       hw_data;
    logic [HW-1:0]           ha_addr;
    logic                    frames_zero;

    assign take     = in_ch.valid & cmd.in_ready;
    assign in_ch.ready = cmd.in_ready;
    assign in_ok    = 32'(in_ch.pixel_index) < NUM_PIXELS;
    assign in_addr  = AW'(in_ch.pixel_index);
    assign idx_addr = AW'(idx_reg);

    // suspect test on the incoming sample
    assign diff  = 34'(in_ch.sample) - 34'(bound_a_reg);
    assign adiff = diff[33] ? -diff : diff;
    always_comb
    begin
        unique case (flag_mode_reg)
            FLAG_SIGMA: sus_raw = adiff >= 34'(bound_b_reg);
            FLAG_RANGE: sus_raw = (in_ch.sample < bound_a_reg) || (in_ch.sample > bound_b_reg);
            default:    sus_raw = 1'b0;
        endcase
        if (flag_mode_reg == FLAG_ALL)
        begin
            sus_in = 1'b1;
        end
        else
        begin
            sus_in = sus_raw && ((in_ch.mask_bits & skip_mask_reg) == 16'd0);
        end
    end

    assign c_val       = idx_ok_reg ? cnt_q : '0;
    assign c_inc       = c_val + HW'(1);
    assign frames_zero = frames_reg == 8'd0;
    assign mp1         = 17'(m_reg) + 17'd1;
    assign frac_prod   = thr_reg * $signed({1'b0, frames_reg});
    assign cnt_shift   = $signed(LIM_W'(c_val) << 32);
    assign reach       = cnt_shift >= cached_reg;

    // one square root digit
    assign rem_sh = {sq_rem_reg[25:0], sq_x_reg[49:48]};
    assign trial  = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge  = rem_sh >= trial;

    // status to controller
    always_comb
    begin
        sts            = '0;
        sts.in_valid   = in_ch.valid;
        sts.in_kind    = in_ch.kind;
        sts.clr_last   = clr_addr_reg == CLR_W'(CLR_N - 1);
        sts.bump_ok    = sus_reg && idx_ok_reg && (32'(c_val) < MAX_COUNT);
        sts.need_limit = !frames_zero && (id_mode_reg != ID_NONE) && !lim_valid_reg;
        sts.id_poisson = id_mode_reg == ID_POISSON;
        sts.mx_last    = 32'(mx_reg) == MAX_COUNT;
        sts.sqrt_last  = 32'(sq_cnt_reg) == SQRT_STEPS - 1;
        sts.out_free   = !out_valid_reg || out_ch.ready;
    end

    // memory write selection
    assign clr_cnt_en  = 32'(clr_addr_reg) < NUM_PIXELS;
    assign clr_hist_en = 32'(clr_addr_reg) <= MAX_COUNT;
    always_comb
    begin
        cw_en   = 1'b0;
        cw_addr = idx_addr;
        cw_data = c_inc;
        hw_en   = 1'b0;
        hw_addr = c_val;
        hw_data = (ha_q != '0) ? ha_q - HIST_W'(1) : ha_q;
        priority if (cmd.clr_step)
        begin
            cw_en   = clr_cnt_en;
            cw_addr = AW'(clr_addr_reg);
            cw_data = '0;
            hw_en   = clr_hist_en;
            hw_addr = HW'(clr_addr_reg);
            hw_data = (clr_addr_reg == '0) ? pix_count_reg : '0;
        end
        else if (cmd.bump_wr1)
        begin
            cw_en = 1'b1;
            hw_en = 1'b1;
        end
        else if (cmd.bump_wr2)
        begin
            hw_en   = 1'b1;
            hw_addr = c_inc;
            hw_data = (hb_q != HIST_MAX) ? hb_q + HIST_W'(1) : hb_q;
        end
    end
    assign ha_addr = cmd.hist_rd ? c_val : mx_reg;

    // count store
    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cnt_mem[cw_addr] <= cw_data;
        end
        if (take)
        begin
            cnt_q <= cnt_mem[in_addr];
        end
    end

    // histogram store, two read ports
    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            hist_mem[hw_addr] <= hw_data;
        end
        if (cmd.hist_rd || cmd.max_rd)
        begin
            ha_q <= hist_mem[ha_addr];
            hb_q <= hist_mem[c_inc];
        end
    end

    // configuration, frames, limit cache and clear address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_mode_reg <= FLAG_SIGMA;
            bound_a_reg   <= '0;
            bound_b_reg   <= '0;
            skip_mask_reg <= '0;
            id_mode_reg   <= ID_FIXED;
            thr_reg       <= 24'sd65536;
            set_mask_reg  <= 16'd1;
            pix_count_reg <= 17'd65536;
            frames_reg    <= '0;
            lim_valid_reg <= 1'b0;
            cached_reg    <= '0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FLAG_MODE:     flag_mode_reg <= cfg_data[1:0];
                    REG_BOUND_A:       bound_a_reg   <= $signed(cfg_data);
                    REG_BOUND_B:       bound_b_reg   <= $signed(cfg_data);
                    REG_SKIP_MASK:     skip_mask_reg <= cfg_data[15:0];
                    REG_IDENTIFY_MODE:
                    begin
                        id_mode_reg   <= cfg_data[1:0];
                        lim_valid_reg <= 1'b0;
                    end
                    REG_THRESHOLD:
                    begin
                        thr_reg       <= $signed(cfg_data[23:0]);
                        lim_valid_reg <= 1'b0;
                    end
                    REG_SET_MASK:      set_mask_reg  <= cfg_data[15:0];
                    REG_PIXEL_COUNT:   pix_count_reg <= cfg_data[16:0];
                    default:           flag_mode_reg <= flag_mode_reg;
                endcase
            end
            if (cmd.clr_start)
            begin
                clr_addr_reg  <= '0;
                frames_reg    <= '0;
                cached_reg    <= '0;
                lim_valid_reg <= 1'b0;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + CLR_W'(1);
            end
            if (cmd.eof && flag_mode_reg != FLAG_ALL && frames_reg < FRAMES_MAX)
            begin
                frames_reg    <= frames_reg + 8'd1;
                lim_valid_reg <= 1'b0;
            end
            if (cmd.bump_wr1)
            begin
                lim_valid_reg <= 1'b0;
            end
            if (cmd.lim_simple)
            begin
                cached_reg    <= (id_mode_reg == ID_FIXED) ? (LIM_W'(thr_reg) <<< 16)
                                                           : (LIM_W'(frac_prod) <<< 16);
                lim_valid_reg <= 1'b1;
            end
            if (cmd.lim_sub)
            begin
                cached_reg    <= $signed(LIM_W'({mp1, 32'd0})) - mul_reg;
                lim_valid_reg <= 1'b1;
            end
        end
    end

    // item latch, peak search, square root and multiply
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg    <= in_ch.pixel_index;
            idx_ok_reg <= in_ok;
            sus_reg    <= sus_in;
        end
        if (cmd.max_start)
        begin
            mx_reg <= '0;
        end
        if (cmd.max_cmp)
        begin
            if (mx_reg == '0 || ha_q > best_reg)
            begin
                best_reg <= ha_q;
                m_reg    <= mx_reg;
            end
            mx_reg <= mx_reg + HW'(1);
        end
        if (cmd.sqrt_start)
        begin
            sq_x_reg    <= {1'b0, mp1, 32'd0};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end
        if (cmd.sqrt_step)
        begin
            sq_rem_reg  <= sq_ge ? rem_sh - trial : rem_sh;
            sq_root_reg <= {sq_root_reg[23:0], sq_ge};
            sq_x_reg    <= {sq_x_reg[47:0], 2'b00};
            sq_cnt_reg  <= sq_cnt_reg + 5'd1;
        end
        if (cmd.lim_mul)
        begin
            mul_reg <= thr_reg * $signed({1'b0, sq_root_reg});
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_idx_reg    <= idx_reg;
            o_cnt_reg    <= 8'(c_val);
            o_status_reg <= frames_zero;
            o_mask_reg   <= (!frames_zero && id_mode_reg != ID_NONE && reach)
                            ? set_mask_reg : 16'd0;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.pixel_index_out   = o_idx_reg;
    assign out_ch.mask_out          = o_mask_reg;
    assign out_ch.suspect_count_out = o_cnt_reg;
    assign out_ch.status            = o_status_reg;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import bpsa_pkg::*;

    // flag mode with no test at all, not named in the package
    localparam logic [1:0] FLAG_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [15:0] mask;
        logic [7:0]  suspect_count;
        logic        status;
    } verdict_t;

    // predicts the classify answers and checks the ones the block returns
    class suspect_scoreboard;
        logic [1:0]       flag_mode;
        int               bound_a;
        int               bound_b;
        logic [15:0]      skip_mask;
        logic [1:0]       identify_mode;
        longint           threshold;
        logic [15:0]      set_mask;
        logic [16:0]      pixel_count;
        logic [7:0]       counts [65536];
        logic [16:0]      histogram [256];
        int               frames;
        longint           limit_q32;
        bit               limit_ok;
        verdict_t         verdicts [$];
        int               errors;

        function new();
            flag_mode = FLAG_SIGMA;
            bound_a = 0;
            bound_b = 0;
            skip_mask = '0;
            identify_mode = ID_FIXED;
            threshold = 65536;
            set_mask = 16'd1;
            pixel_count = 17'd65536;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (counts[i]) counts[i] = '0;
            foreach (histogram[i]) histogram[i] = '0;
            histogram[0] = pixel_count;
            frames = 0;
            limit_q32 = 0;
            limit_ok = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [31:0] data);
            case (index)
                REG_FLAG_MODE:     flag_mode = data[1:0];
                REG_BOUND_A:       bound_a = data;
                REG_BOUND_B:       bound_b = data;
                REG_SKIP_MASK:     skip_mask = data[15:0];
                REG_IDENTIFY_MODE: begin identify_mode = data[1:0]; limit_ok = 0; end
                REG_THRESHOLD:     begin threshold = longint'($signed(data[23:0])); limit_ok = 0; end
                REG_SET_MASK:      set_mask = data[15:0];
                REG_PIXEL_COUNT:   pixel_count = data[16:0];
                default: ;
            endcase
        endfunction

        // raise one pixel count, moving it between histogram bins
        function void raise_count(logic [15:0] idx);
            int c;
            c = counts[idx];
            if (c >= 255)
                return;
            if (histogram[c] != 0)
                histogram[c] = histogram[c] - 1;
            if (histogram[c + 1] != HIST_MAX)
                histogram[c + 1] = histogram[c + 1] + 1;
            counts[idx] = c + 1;
            limit_ok = 0;
        endfunction

        function longint unsigned root_q(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // limit in Q32.32
        function longint bad_limit();
            int peak;
            longint unsigned root;
            longint unsigned scaled;
            if (identify_mode == ID_FIXED)
                return threshold * 65536;
            if (identify_mode == ID_FRACTION)
                return threshold * longint'(frames) * 65536;
            peak = 0;
            for (int i = 1; i < 256; i++)
                if (histogram[i] > histogram[peak])
                    peak = i;
            scaled = longint'(peak + 1) << 32;
            root = root_q(scaled);
            return longint'(scaled) - threshold * longint'(root);
        endfunction

        function void note_item(logic [1:0] kind, logic [15:0] idx, logic [31:0] smp,
                                logic [15:0] mbits);
            longint gap;
            bit flagged;
            verdict_t v;
            case (kind)
                KIND_SAMPLE:
                begin
                    flagged = 0;
                    if (flag_mode == FLAG_ALL)
                        raise_count(idx);
                    else
                    begin
                        if (flag_mode == FLAG_SIGMA)
                        begin
                            gap = longint'($signed(smp)) - longint'(bound_a);
                            if (gap < 0)
                                gap = -gap;
                            flagged = gap >= longint'(bound_b);
                        end
                        else if (flag_mode == FLAG_RANGE)
                            flagged = ($signed(smp) < bound_a) || ($signed(smp) > bound_b);
                        if (flagged && (mbits & skip_mask) == 0)
                            raise_count(idx);
                    end
                end
                KIND_EOF:
                    if (flag_mode != FLAG_ALL && frames < 255)
                    begin
                        frames++;
                        limit_ok = 0;
                    end
                KIND_CLEAR:
                    wipe();
                default:
                begin
                    v.pixel_index = idx;
                    v.suspect_count = counts[idx];
                    v.mask = '0;
                    v.status = 1'b0;
                    if (frames == 0)
                        v.status = 1'b1;
                    else if (identify_mode != ID_NONE)
                    begin
                        if (!limit_ok)
                        begin
                            limit_q32 = bad_limit();
                            limit_ok = 1;
                        end
                        if ((longint'(counts[idx]) << 32) >= limit_q32)
                            v.mask = set_mask;
                    end
                    verdicts.push_back(v);
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(verdict_t got);
            verdict_t want;
            if (verdicts.size() == 0)
            begin
                report($sformatf("unexpected result for pixel %0d", got.pixel_index));
                return;
            end
            want = verdicts.pop_front();
            if (got.pixel_index != want.pixel_index)
                report($sformatf("pixel %0d, expected %0d", got.pixel_index, want.pixel_index));
            if (got.mask != want.mask)
                report($sformatf("pixel %0d mask %h, expected %h", want.pixel_index,
                                 got.mask, want.mask));
            if (got.suspect_count != want.suspect_count)
                report($sformatf("pixel %0d count %0d, expected %0d", want.pixel_index,
                                 got.suspect_count, want.suspect_count));
            if (got.status != want.status)
                report($sformatf("pixel %0d status %0d, expected %0d", want.pixel_index,
                                 got.status, want.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          send_gap_pct;
    int          recv_stall_pct;
    int          cycles;

    bpsa_in_if  in_ch ();
    bpsa_out_if out_ch ();

    suspect_scoreboard sb;

    bad_pixel_suspect_accumulator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // result check on each output transfer
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.pixel_index_out, out_ch.mask_out,
                             out_ch.suspect_count_out, out_ch.status});

    // register write, starting and ending on a falling edge; no item offered meanwhile
    task write_reg(logic [2:0] index, logic [31:0] data);
        in_ch.valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // one input transfer; valid is left high for the next item
    task put(logic [1:0] kind, logic [15:0] idx, logic [31:0] smp, logic [15:0] mbits);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.pixel_index <= idx;
        in_ch.sample <= smp;
        in_ch.mask_bits <= mbits;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_item(kind, idx, smp, mbits);
        @(negedge clk);
    endtask

    // sender holds off until every pending answer is back
    task wait_answers();
        in_ch.valid <= 1'b0;
        while (sb.verdicts.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // closing classify makes sure earlier work is done before registers change
    task settle();
        put(KIND_CLASSIFY, 16'd0, 32'd0, 16'd0);
        wait_answers();
        repeat (8) @(negedge clk);
    endtask

    task set_idling(int phase);
        case (phase % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
            default: begin send_gap_pct = 16; recv_stall_pct = 16; end
        endcase
    endtask

    function logic [31:0] pick_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3)
            return $urandom;
        if (sel < 6)
            return sb.bound_a + ($urandom_range(1) ? sb.bound_b : -sb.bound_b)
                   + $urandom_range(2) - 1;
        return sb.bound_a + $urandom_range(8 << 16) - (4 << 16);
    endfunction

    function logic [15:0] pick_pixel();
        if ($urandom_range(3) != 0)
            return $urandom_range(15);
        return $urandom;
    endfunction

    // random phase: new registers, then a mix of samples, frames and classifies
    task random_phase(int phase, int n);
        int sel;
        write_reg(REG_FLAG_MODE, ($urandom_range(9) == 0) ? FLAG_NONE : $urandom_range(2));
        write_reg(REG_BOUND_A, ($urandom_range(4) == 0) ? $urandom
                                                        : $urandom_range(4 << 16) - (2 << 16));
        write_reg(REG_BOUND_B, ($urandom_range(4) == 0) ? $urandom : $urandom_range(3 << 16));
        write_reg(REG_SKIP_MASK, 16'd1 << $urandom_range(15));
        write_reg(REG_IDENTIFY_MODE, $urandom_range(3));
        case ($urandom_range(3))
            0: write_reg(REG_THRESHOLD, $urandom);
            1: write_reg(REG_THRESHOLD, $urandom_range(4 << 16));
            2: write_reg(REG_THRESHOLD, $urandom_range(1 << 16));
            default: write_reg(REG_THRESHOLD, 32'hFFFF0000 | $urandom_range(16'hFFFF));
        endcase
        write_reg(REG_SET_MASK, $urandom);
        if (phase % 3 == 0)
        begin
            write_reg(REG_PIXEL_COUNT, ($urandom_range(1) != 0) ? $urandom_range(1, 64)
                                                               : $urandom_range(1, 65536));
            put(KIND_CLEAR, $urandom, $urandom, $urandom);
        end
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(99);
            if (sel == 0)
                wait_answers();
            if (sel < 10)
                put(KIND_EOF, $urandom, $urandom, $urandom);
            else if (sel < 35)
                put(KIND_CLASSIFY, pick_pixel(), $urandom, $urandom);
            else
                put(KIND_SAMPLE, pick_pixel(), pick_sample(),
                    ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom));
        end
        settle();
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_SAMPLE;
        in_ch.pixel_index = '0;
        in_ch.sample = '0;
        in_ch.mask_bits = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no frames yet: status set, then idle for register writes
        settle();

        // sigma test around its boundary and the value extremes
        write_reg(REG_FLAG_MODE, FLAG_SIGMA);
        write_reg(REG_BOUND_A, 32'h0001_0000);
        write_reg(REG_BOUND_B, 32'h0000_8000);
        write_reg(REG_SKIP_MASK, 16'h8000);
        write_reg(REG_IDENTIFY_MODE, ID_FIXED);
        write_reg(REG_THRESHOLD, 32'h0000_0001);
        write_reg(REG_SET_MASK, 16'hFFFF);
        write_reg(REG_PIXEL_COUNT, 17'd65536);
        put(KIND_SAMPLE, 16'd0, 32'h0001_8000, 16'd0);
        put(KIND_SAMPLE, 16'd1, 32'h0001_7FFF, 16'd0);
        put(KIND_SAMPLE, 16'd2, 32'h8000_0000, 16'h7FFF);
        put(KIND_SAMPLE, 16'd3, 32'h7FFF_FFFF, 16'hFFFF);
        put(KIND_SAMPLE, 16'hFFFF, 32'h8000_0000, 16'd0);
        put(KIND_EOF, 16'd0, 32'd0, 16'd0);
        put(KIND_CLASSIFY, 16'd0, 32'd0, 16'd0);
        put(KIND_CLASSIFY, 16'd3, 32'd0, 16'd0);
        put(KIND_CLASSIFY, 16'hFFFF, 32'd0, 16'd0);
        settle();

        // value range test at its limits, fraction and no identify
        write_reg(REG_FLAG_MODE, FLAG_RANGE);
        write_reg(REG_BOUND_A, 32'hFFFB_0000);
        write_reg(REG_BOUND_B, 32'h0005_0000);
        write_reg(REG_IDENTIFY_MODE, ID_FRACTION);
        write_reg(REG_THRESHOLD, 32'h007F_FFFF);
        put(KIND_SAMPLE, 16'd4, 32'hFFFB_0000, 16'd0);
        put(KIND_SAMPLE, 16'd4, 32'hFFFA_FFFF, 16'd0);
        put(KIND_SAMPLE, 16'd5, 32'h0005_0001, 16'd0);
        put(KIND_CLASSIFY, 16'd4, 32'd0, 16'd0);
        settle();
        write_reg(REG_IDENTIFY_MODE, ID_NONE);
        write_reg(REG_THRESHOLD, 32'h0080_0000);
        put(KIND_CLASSIFY, 16'd4, 32'd0, 16'd0);
        settle();

        // negative span flags everything; no-flag mode still counts frames
        write_reg(REG_FLAG_MODE, FLAG_SIGMA);
        write_reg(REG_BOUND_B, 32'hFFFF_FFFF);
        write_reg(REG_IDENTIFY_MODE, ID_POISSON);
        put(KIND_SAMPLE, 16'd6, 32'd0, 16'd0);
        wait_answers();
        repeat (4) @(negedge clk);
        write_reg(REG_FLAG_MODE, FLAG_NONE);
        put(KIND_SAMPLE, 16'd7, 32'd0, 16'd0);
        put(KIND_EOF, 16'd0, 32'd0, 16'd0);
        put(KIND_CLASSIFY, 16'd6, 32'd0, 16'd0);
        settle();

        // flag-all mode raises counts on pixels 0 to 3 of a small image
        write_reg(REG_PIXEL_COUNT, 17'd16);
        write_reg(REG_FLAG_MODE, FLAG_ALL);
        write_reg(REG_THRESHOLD, 32'h0000_8000);
        put(KIND_CLEAR, 16'd0, 32'd0, 16'd0);
        for (int k = 0; k < 300; k++)
            put(KIND_SAMPLE, $urandom_range(3), $urandom, $urandom);
        put(KIND_EOF, 16'd0, 32'd0, 16'd0);
        put(KIND_CLASSIFY, 16'd1, 32'd0, 16'd0);
        settle();

        // frame count saturation
        set_idling(1);
        write_reg(REG_FLAG_MODE, FLAG_NONE);
        write_reg(REG_IDENTIFY_MODE, ID_FRACTION);
        write_reg(REG_THRESHOLD, 32'h0000_0100);
        for (int k = 0; k < 260; k++)
            put(KIND_EOF, $urandom, $urandom, $urandom);
        put(KIND_CLASSIFY, 16'd2, 32'd0, 16'd0);
        settle();

        for (int p = 0; p < 12; p++)
        begin
            set_idling(p);
            random_phase(p, 60);
        end

        in_ch.valid <= 1'b0;
        while (sb.verdicts.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== bad_pixel_suspect_accumulator_core.f =====
sv/bpsa_pkg.sv
sv/bpsa_in_if.sv
sv/bpsa_out_if.sv
sv/bpsa_ctrl.sv
sv/bpsa_dp.sv
sv/bad_pixel_suspect_accumulator_core.sv
sim/testbench.sv
